// ===== rtl/dsj_pkg.sv =====
// Shared types and constants for the damped spring joint step.
`default_nettype none

package dsj_pkg;

    localparam int unsigned AXES     = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned REG_W    = 64;
    localparam int unsigned ADDR_W   = 6;
    localparam int unsigned IN_W     = AXES * DATA_W;
    localparam int unsigned OUT_W    = 2 * AXES * DATA_W;

    localparam logic [DATA_W-1:0] ONE_FP = 32'h0001_0000;

    // Register indexes, decoded from paddr[5:3]
    localparam logic [2:0] REG_GAINS_X  = 3'd0;
    localparam logic [2:0] REG_GAINS_Y  = 3'd1;
    localparam logic [2:0] REG_GAINS_Z  = 3'd2;
    localparam logic [2:0] REG_LIMITS_X = 3'd3;
    localparam logic [2:0] REG_LIMITS_Y = 3'd4;
    localparam logic [2:0] REG_LIMITS_Z = 3'd5;

    typedef struct packed {
        logic start;    // beat accepted: form the products
        logic fire;     // finish the tick and update the state
    } lane_ctrl_t;

    typedef struct packed {
        logic [DATA_W-1:0] vel;
        logic [DATA_W-1:0] pos;
    } lane_res_t;

endpackage

`default_nettype wire

// ===== rtl/dsj_lane.sv =====
// One axis of the spring joint: product stage, then sum, clamp and state update.
`default_nettype none

module dsj_lane
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dsj_pkg::lane_ctrl_t           ctrl,
    input  wire logic [dsj_pkg::REG_W-1:0]     gains,
    input  wire logic [dsj_pkg::REG_W-1:0]     limits,
    input  wire logic [dsj_pkg::DATA_W-1:0]    nudge,
    output logic      [dsj_pkg::DATA_W-1:0]    pos_new,
    output logic      [dsj_pkg::DATA_W-1:0]    vel_new
);
    import dsj_pkg::*;

    logic [DATA_W-1:0]     pos_reg;
    logic [DATA_W-1:0]     vel_reg;
    logic [DATA_W-1:0]     spring_reg;
    logic [DATA_W-1:0]     drag_reg;
    logic [DATA_W-1:0]     nudge_reg;

    logic signed [DATA_W-1:0]   stiff;
    logic signed [DATA_W-1:0]   neg_pos;
    logic signed [DATA_W-1:0]   keep;
    logic signed [DATA_W-1:0]   vel_s;
    logic signed [2*DATA_W-1:0] spring_prod;
    logic signed [2*DATA_W-1:0] drag_prod;

    logic [DATA_W-1:0]          accel;
    logic [DATA_W-1:0]          vel_sum;
    logic [DATA_W-1:0]          pos_sum;
    logic signed [DATA_W-1:0]   pos_ext;
    logic signed [DATA_W-1:0]   lim_max;
    logic signed [DATA_W-1:0]   lim_min;

    always_comb
    begin
        stiff       = signed'(gains[REG_W-1:DATA_W]);
        neg_pos     = signed'(DATA_W'(0) - pos_reg);
        keep        = signed'(ONE_FP - gains[DATA_W-1:0]);
        vel_s       = signed'(vel_reg);
        spring_prod = (2*DATA_W)'(stiff) * (2*DATA_W)'(neg_pos);
        drag_prod   = (2*DATA_W)'(keep) * (2*DATA_W)'(vel_s);
    end

    // Hold the product slices for the sum and write-back step
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            spring_reg <= spring_prod[FRAC_W+DATA_W-1:FRAC_W];
            drag_reg   <= drag_prod[FRAC_W+DATA_W-1:FRAC_W];
            nudge_reg  <= nudge;
        end
    end

    always_comb
    begin
        accel   = spring_reg - drag_reg + nudge_reg;
        vel_sum = vel_reg + accel;
        pos_sum = pos_reg + vel_sum;
        // Wrap the position to 28 bits
        pos_ext = signed'({{(DATA_W-28){pos_sum[27]}}, pos_sum[27:0]});
        lim_max = signed'(limits[REG_W-1:DATA_W]);
        lim_min = signed'(limits[DATA_W-1:0]);
        priority if (pos_ext > lim_max)
        begin
            pos_new = unsigned'(lim_max);
            vel_new = '0;
        end
        else if (pos_ext < lim_min)
        begin
            pos_new = unsigned'(lim_min);
            vel_new = '0;
        end
        else
        begin
            pos_new = unsigned'(pos_ext);
            vel_new = vel_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
        end
        else if (ctrl.fire)
        begin
            pos_reg <= pos_new;
            vel_reg <= vel_new;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dsj_merge.sv =====
// Output register that gathers the three lane results into one beat.
`default_nettype none

module dsj_merge
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire dsj_pkg::lane_res_t          res [dsj_pkg::AXES],
    output logic                             slot_free,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic     [dsj_pkg::OUT_W-1:0]    m_tdata
);
    import dsj_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [OUT_W-1:0]  data_reg;
    logic [OUT_W-1:0]  packed_res;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            packed_res[a*DATA_W +: DATA_W]          = res[a].pos;
            packed_res[(AXES+a)*DATA_W +: DATA_W]   = res[a].vel;
        end
    end

    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= packed_res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/damped_spring_joint_step.sv =====
// Top level of the three-axis damped spring joint step.
//
//  group    | direction | contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata[95:0]: nudge_x, nudge_y, nudge_z
//  m_axis   | out       | tdata[191:0]: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
//  apb      | in/out    | gains_x..z at 0x00..0x10, limits_x..z at 0x18..0x28
//
// A tick first forms both 32x32 products of every axis and registers them,
// then sums, clamps and writes back position and velocity.
// The state recurrence through the lanes lets a new beat in only after write-back.
// A finished result waits in the output register; a new beat is taken
// meanwhile, and only the write-back stalls while that register is full.
// Reset clears state, configuration registers and valid flags.
`default_nettype none

module damped_spring_joint_step
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dsj_pkg::IN_W-1:0]      s_tdata,   // nudge_x, nudge_y, nudge_z
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [dsj_pkg::OUT_W-1:0]     m_tdata,   // pos_x..z, vel_x..z
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dsj_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [dsj_pkg::REG_W-1:0]     pwdata,
    output logic      [dsj_pkg::REG_W-1:0]     prdata,
    output logic                               pready
);
    import dsj_pkg::*;

    logic [REG_W-1:0]  gains_reg  [AXES];
    logic [REG_W-1:0]  limits_reg [AXES];
    logic              busy_reg;
    logic              busy_next;
    logic              accept;
    logic              slot_free;
    logic              fire;
    lane_ctrl_t        ctrl;
    lane_res_t         res [AXES];
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                gains_reg[a]  <= '0;
                limits_reg[a] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GAINS_X:  gains_reg[0]  <= pwdata;
                REG_GAINS_Y:  gains_reg[1]  <= pwdata;
                REG_GAINS_Z:  gains_reg[2]  <= pwdata;
                REG_LIMITS_X: limits_reg[0] <= pwdata;
                REG_LIMITS_Y: limits_reg[1] <= pwdata;
                REG_LIMITS_Z: limits_reg[2] <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAINS_X:  prdata = gains_reg[0];
            REG_GAINS_Y:  prdata = gains_reg[1];
            REG_GAINS_Z:  prdata = gains_reg[2];
            REG_LIMITS_X: prdata = limits_reg[0];
            REG_LIMITS_Y: prdata = limits_reg[1];
            REG_LIMITS_Z: prdata = limits_reg[2];
            default:      prdata = '0;
        endcase
    end

    // Products depend on the state, so hold new beats until write-back
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign fire      = busy_reg && slot_free;
    assign busy_next = accept || (busy_reg && !fire);
    assign ctrl      = '{start: accept, fire: fire};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        dsj_lane u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .gains   (gains_reg[a]),
            .limits  (limits_reg[a]),
            .nudge   (s_tdata[a*DATA_W +: DATA_W]),
            .pos_new (res[a].pos),
            .vel_new (res[a].vel)
        );
    end

    dsj_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
